@@ hdl/two_way_lru_cache_controller_unit_assert.svh @@
// Assertion macros shared by the cache controller modules
`ifndef TWO_WAY_LRU_CACHE_CONTROLLER_UNIT_ASSERT_SVH
`define TWO_WAY_LRU_CACHE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define TWLRU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TWLRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/twlru_pkg.sv @@
// Types, constants and helper functions of the two-way LRU cache controller
package twlru_pkg;

   localparam int ADDR_W              = 32;
   localparam int COST_W              = 16;
   localparam int ACCESS_COST_W       = 18;
   localparam int TOTAL_W             = 32;
   localparam int WAY_COUNT           = 2;
   localparam int SET_COUNT_DEFAULT   = 256;
   localparam int BLOCK_BYTES_DEFAULT = 64;

   localparam logic [COST_W-1:0] CACHE_READ_COST_RESET   = 16'd1;
   localparam logic [COST_W-1:0] CACHE_WRITE_COST_RESET  = 16'd1;
   localparam logic [COST_W-1:0] MEMORY_READ_COST_RESET  = 16'd100;
   localparam logic [COST_W-1:0] MEMORY_WRITE_COST_RESET = 16'd50;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_CACHE_READ_COST   = 2'd0,
      CSR_CACHE_WRITE_COST  = 2'd1,
      CSR_MEMORY_READ_COST  = 2'd2,
      CSR_MEMORY_WRITE_COST = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              kind;
   } req_word_type;

   typedef struct packed {
      logic                     hit;
      logic                     way_used;
      logic [ADDR_W-1:0]        refill_address;
      logic                     writeback_needed;
      logic [ADDR_W-1:0]        victim_address;
      logic [ACCESS_COST_W-1:0] access_cost;
      logic [TOTAL_W-1:0]       elapsed_total;
   } rsp_word_type;

   // Per-set policy bits kept next to the tags
   typedef struct packed {
      logic                 lru;
      logic [WAY_COUNT-1:0] valid;
      logic [WAY_COUNT-1:0] dirty;
   } set_flags_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic decide;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctrl_status_type;

   // Elaboration-time floor of log2
   function automatic int floor_log2(input int value);
      int v;
      int n;
      v = value;
      n = 0;
      while (v > 1) begin
         v = v >> 1;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

@@ hdl/two_way_lru_cache_controller_unit.sv @@
// Top level of the two-way set-associative LRU write-back cache tag controller
//
//   port group | direction | handshake           | word
//   req_       | in        | req_valid/req_stall | req_word_type  (address, kind)
//   rsp_       | out       | rsp_valid/rsp_stall | rsp_word_type  (hit ... elapsed_total)
//   csr_       | in        | csr_write           | csr_index, csr_data (16 bits)
//
// An access has these steps: accept with registered tag/flag read, decide and
// write the set back, load the result register; the next word is accepted after.
// A word still stalled in the result register holds the following access in its
// last step, which delays the acceptance after it.
// After reset a clearing pass writes the flag memory one set per cycle, covering all
// 2**floor(log2(SET_COUNT)) sets (256 by default), while req_stall stays high.
// Configuration writes are taken in any cycle, including the clearing pass.
module two_way_lru_cache_controller_unit
   import twlru_pkg::*;
#(
   parameter int SET_COUNT   = SET_COUNT_DEFAULT,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word,
   input  logic              csr_write,
   input  csr_index_type     csr_index,
   input  logic [COST_W-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer
   twlru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Stores and decision logic
   twlru_datapath #(
      .SET_COUNT   (SET_COUNT),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_word  (rsp_word)
   );

endmodule

@@ hdl/twlru_ctrl.sv @@
// Sequencer of the cache controller: clearing pass, lookup, update, result handoff
module twlru_ctrl
   import twlru_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

`include "two_way_lru_cache_controller_unit_assert.svh"

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           slot_free;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      slot_free   = !rsp_valid_ff || !rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.decide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // Hold the word until taken, load a new one when the slot frees
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TWLRU_ASSERT_NEXT(a_accept_to_lookup, clock, reset, req_valid && !req_stall,
                      state_ff == ST_LOOKUP, "accepted word did not enter lookup")
   `TWLRU_ASSERT_NEXT(a_lookup_to_finish, clock, reset, state_ff == ST_LOOKUP,
                      state_ff == ST_FINISH, "lookup did not advance to finish")
   `TWLRU_ASSERT_NEXT(a_finish_loads_rsp, clock, reset, cmd.finish,
                      rsp_valid_ff, "finished access left no result word")

endmodule

@@ hdl/twlru_datapath.sv @@
// Tag and policy stores, hit and victim decision, cost accounting, result register
module twlru_datapath
   import twlru_pkg::*;
#(
   parameter int SET_COUNT   = SET_COUNT_DEFAULT,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status,
   input  req_word_type        req_word,
   input  logic                csr_write,
   input  csr_index_type       csr_index,
   input  logic [COST_W-1:0]   csr_data,
   output rsp_word_type        rsp_word
);

`include "two_way_lru_cache_controller_unit_assert.svh"

   localparam int OFF_W = floor_log2(BLOCK_BYTES);
   localparam int IDX_W = floor_log2(SET_COUNT);
   localparam int TAG_W = ADDR_W - OFF_W - IDX_W;
   localparam int SETS  = 1 << IDX_W;

   // Tag and flag memories, one row per set
   logic [TAG_W-1:0] tag0_mem [SETS];
   logic [TAG_W-1:0] tag1_mem [SETS];
   set_flags_type    flag_mem [SETS];

   logic [TAG_W-1:0]  tag0_rd_ff;
   logic [TAG_W-1:0]  tag1_rd_ff;
   set_flags_type     flag_rd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              kind_ff;
   logic [IDX_W-1:0]  clear_idx_ff;
   logic [COST_W-1:0] cache_read_cost_ff;
   logic [COST_W-1:0] cache_write_cost_ff;
   logic [COST_W-1:0] memory_read_cost_ff;
   logic [COST_W-1:0] memory_write_cost_ff;
   logic [TOTAL_W-1:0] elapsed_ff;
   logic [TOTAL_W-1:0] elapsed_in;
   rsp_word_type      decision_ff;
   rsp_word_type      decision_in;
   rsp_word_type      rsp_word_ff;
   rsp_word_type      rsp_word_in;

   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  set_idx;
   logic [TAG_W-1:0]  tag;
   logic              match0;
   logic              match1;
   logic              hit;
   logic              way_sel;
   logic [TAG_W-1:0]  victim_tag;
   logic              wb;
   logic [COST_W-1:0] cache_cost;
   set_flags_type     new_flags;
   logic              tag0_we;
   logic              tag1_we;
   logic              flag_we;
   logic [IDX_W-1:0]  flag_wr_idx;
   set_flags_type     flag_wr_data;

   assign rd_idx  = req_word.address[OFF_W +: IDX_W];
   assign set_idx = addr_ff[OFF_W +: IDX_W];
   assign tag     = addr_ff[ADDR_W-1 -: TAG_W];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_read_cost_ff   <= CACHE_READ_COST_RESET;
         cache_write_cost_ff  <= CACHE_WRITE_COST_RESET;
         memory_read_cost_ff  <= MEMORY_READ_COST_RESET;
         memory_write_cost_ff <= MEMORY_WRITE_COST_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CACHE_READ_COST:   cache_read_cost_ff   <= csr_data;
            CSR_CACHE_WRITE_COST:  cache_write_cost_ff  <= csr_data;
            CSR_MEMORY_READ_COST:  memory_read_cost_ff  <= csr_data;
            CSR_MEMORY_WRITE_COST: memory_write_cost_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Advance the clearing pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   assign status.clear_last = &clear_idx_ff;

   // Capture the access and read its set
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff    <= req_word.address;
         kind_ff    <= req_word.kind;
         tag0_rd_ff <= tag0_mem[rd_idx];
         tag1_rd_ff <= tag1_mem[rd_idx];
         flag_rd_ff <= flag_mem[rd_idx];
      end
   end

   // Hit, victim choice, cost and new set flags
   always_comb begin
      match0     = flag_rd_ff.valid[0] && (tag0_rd_ff == tag);
      match1     = flag_rd_ff.valid[1] && (tag1_rd_ff == tag);
      hit        = match0 || match1;
      if (hit) begin
         way_sel = !match0;
      end else if (!flag_rd_ff.valid[0]) begin
         way_sel = 1'b0;
      end else if (!flag_rd_ff.valid[1]) begin
         way_sel = 1'b1;
      end else begin
         way_sel = flag_rd_ff.lru;
      end
      victim_tag = way_sel ? tag1_rd_ff : tag0_rd_ff;
      wb         = !hit && flag_rd_ff.valid[way_sel] && flag_rd_ff.dirty[way_sel];
      cache_cost = kind_ff ? cache_write_cost_ff : cache_read_cost_ff;

      decision_in                  = '0;
      decision_in.hit              = hit;
      decision_in.way_used         = way_sel;
      decision_in.writeback_needed = wb;
      if (!hit) begin
         decision_in.refill_address = {addr_ff[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
      end
      if (wb) begin
         decision_in.victim_address = {victim_tag, set_idx, {OFF_W{1'b0}}};
      end
      decision_in.access_cost =
         (hit ? '0 : {2'b00, memory_read_cost_ff}) +
         (wb ? {2'b00, memory_write_cost_ff} : '0) +
         {2'b00, cache_cost};

      new_flags                 = flag_rd_ff;
      new_flags.valid[way_sel]  = 1'b1;
      new_flags.dirty[way_sel]  = (hit && flag_rd_ff.dirty[way_sel]) || kind_ff;
      new_flags.lru             = !way_sel;

      tag0_we      = cmd.decide && !hit && !way_sel;
      tag1_we      = cmd.decide && !hit && way_sel;
      flag_we      = cmd.clear || cmd.decide;
      flag_wr_idx  = cmd.clear ? clear_idx_ff : set_idx;
      flag_wr_data = cmd.clear ? set_flags_type'('0) : new_flags;
   end

   // Write back the set
   always_ff @(posedge clock) begin
      if (tag0_we) begin
         tag0_mem[set_idx] <= tag;
      end
      if (tag1_we) begin
         tag1_mem[set_idx] <= tag;
      end
      if (flag_we) begin
         flag_mem[flag_wr_idx] <= flag_wr_data;
      end
   end

   // Hold the decision for the result stage
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         decision_ff <= decision_in;
      end
   end

   // Accumulate time and load the result word
   assign elapsed_in = elapsed_ff +
                       {{(TOTAL_W-ACCESS_COST_W){1'b0}}, decision_ff.access_cost};

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else if (cmd.finish) begin
         elapsed_ff <= elapsed_in;
      end
   end

   always_comb begin
      rsp_word_in               = decision_ff;
      rsp_word_in.elapsed_total = elapsed_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_word = rsp_word_ff;

   `TWLRU_ASSERT_NOW(a_hit_no_refill, clock, reset, cmd.decide && hit,
                     !tag0_we && !tag1_we && !wb, "hit refilled or evicted a block")
   `TWLRU_ASSERT_NOW(a_victim_only_wb, clock, reset,
                     cmd.finish && !decision_ff.writeback_needed,
                     decision_ff.victim_address == '0, "victim address without write-back")
   `TWLRU_ASSERT_NEXT(a_decide_marks_valid, clock, reset, cmd.decide,
                      flag_mem[$past(set_idx)].valid[$past(way_sel)],
                      "used way not valid after update")

endmodule
